>>> rtl/jlbr_pkg.sv
// ============================================================================
// jlbr_pkg
// Shared types and constants for the joint limit barrier row generator:
// register indexes, pipeline stage records and the bound rounding function.
// ============================================================================
package jlbr_pkg;

    // Joints per pass and rows per pass supported by this build.
    localparam logic [6:0]  MAX_JOINTS = 7'd16;
    localparam logic [12:0] MAX_ROWS   = 13'd256;

    // Hard row limit: the least of the row budget and 256 row numbers.
    localparam logic [8:0] CAP_LIMIT = (MAX_ROWS < 13'd256) ? MAX_ROWS[8:0] : 9'd256;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_INFLUENCE   = 3'd0,
        REG_SAFETY      = 3'd1,
        REG_GAIN_LOWER  = 3'd2,
        REG_GAIN_UPPER  = 3'd3,
        REG_FIRST_ROW   = 3'd4,
        REG_ROW_CAP     = 3'd5
    } cfg_index_t;

    // Row emission state of the last stage.
    typedef enum logic [1:0] {
        EMIT_FIRST = 2'b01,
        EMIT_UPPER = 2'b10
    } emit_state_t;

    // Input register contents.
    typedef struct packed {
        logic               pass_start;
        logic [3:0]         joint_id;
        logic signed [31:0] position;
        logic signed [31:0] limit_min;
        logic signed [31:0] limit_max;
    } in_item_t;

    // Partial products of both candidate rows.
    typedef struct packed {
        logic               pass_start;
        logic [3:0]         joint_id;
        logic               want_low;
        logic               want_up;
        logic [41:0]        pl_low;
        logic signed [41:0] ph_low;
        logic [41:0]        pl_up;
        logic signed [41:0] ph_up;
    } prod_item_t;

    // Finished bounds waiting for row numbering.
    typedef struct packed {
        logic               pass_start;
        logic [3:0]         joint_id;
        logic               want_low;
        logic               want_up;
        logic signed [31:0] bound_low;
        logic signed [31:0] bound_high;
    } bound_item_t;

    // Joins the high and low partial products of a gain times distance
    // product (Q.32), rounds to Q15.16 with ties upward and saturates.
    function automatic logic signed [31:0] round_bound(
        input logic [41:0]        pl,
        input logic signed [41:0] ph
    );
        logic signed [59:0] p;
        logic signed [60:0] t;
        logic signed [44:0] r;
        logic signed [31:0] res;
        p = $signed({ph, 18'b0}) + $signed({18'b0, pl});
        t = $signed({p[59], p}) + 61'sd32768;
        r = t[60:16];
        if (r > 45'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (r < -45'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = r[31:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/joint_limit_barrier_rows_core.sv
// ============================================================================
// joint_limit_barrier_rows_core
// Turns one joint (position and limits) into up to two barrier velocity
// constraint rows, numbered consecutively within a pass.
// ============================================================================
// An item enters the input register, the next stage forms the zone tests and
// the split gain products, the one after that rounds and saturates both
// bounds, and the last stage numbers the rows and loads the output register.
// An item that yields no row or one row leaves the last stage when its row,
// if any, is loaded; an item that yields both a lower and an upper row stays
// until its upper row is loaded too, because the output register hands out
// one row per cycle while m_tready holds. Rows are numbered in the last stage,
// so numbering and capacity follow item order regardless of stalls.
module joint_limit_barrier_rows_core (
    input  logic          aclk,
    input  logic          aresetn,
    // Configuration write port.
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [30:0]   cfg_wdata,
    // Joint items.
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: joint_id[3:0], position[35:4], limit_min[67:36], limit_max[99:68]
    input  logic [103:0]  s_tdata,
    // tuser: pass_start[0]
    input  logic          s_tuser,
    // Constraint rows.
    output logic          m_tvalid,
    input  logic          m_tready,
    // tdata: row_number[7:0], column[11:8], bound_low[43:12], bound_high[75:44]
    output logic [79:0]   m_tdata,
    // tuser: low_unbounded[0], high_unbounded[1]
    output logic [1:0]    m_tuser,
    // tlast: last_of_item
    output logic          m_tlast
);
    import jlbr_pkg::*;

    // Configuration registers.
    logic [30:0] influence_reg;
    logic [30:0] safety_reg;
    logic [23:0] gain_lower_reg;
    logic [23:0] gain_upper_reg;
    logic [7:0]  first_row_reg;
    logic [8:0]  row_cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            influence_reg  <= '0;
            safety_reg     <= '0;
            gain_lower_reg <= '0;
            gain_upper_reg <= '0;
            first_row_reg  <= '0;
            row_cap_reg    <= 9'd256;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_INFLUENCE:  influence_reg  <= cfg_wdata;
                REG_SAFETY:     safety_reg     <= cfg_wdata;
                REG_GAIN_LOWER: gain_lower_reg <= cfg_wdata[23:0];
                REG_GAIN_UPPER: gain_upper_reg <= cfg_wdata[23:0];
                REG_FIRST_ROW:  first_row_reg  <= cfg_wdata[7:0];
                REG_ROW_CAP:    row_cap_reg    <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Pipeline registers and handshake.
    logic        s0_valid_reg, s1_valid_reg, s2_valid_reg;
    in_item_t    s0_reg;
    prod_item_t  s1_reg, s1_next;
    bound_item_t s2_reg, s2_next;
    logic        s0_ready, s1_ready, s2_ready, s2_done;

    assign s2_ready = !s2_valid_reg || s2_done;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;
    assign s_tready = s0_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_ready) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_ready && s_tvalid) begin
            s0_reg.pass_start <= s_tuser;
            s0_reg.joint_id   <= s_tdata[3:0];
            s0_reg.position   <= s_tdata[35:4];
            s0_reg.limit_min  <= s_tdata[67:36];
            s0_reg.limit_max  <= s_tdata[99:68];
        end
    end

    // Zone tests, safe-limit distances and split products.
    logic signed [34:0] q_x, qmin_x, qmax_x, safe_x, infl_x;
    logic signed [34:0] low_safe, up_safe, d_low, d_up;
    logic               item_ok;

    always_comb begin
        q_x      = {{3{s0_reg.position[31]}}, s0_reg.position};
        qmin_x   = {{3{s0_reg.limit_min[31]}}, s0_reg.limit_min};
        qmax_x   = {{3{s0_reg.limit_max[31]}}, s0_reg.limit_max};
        safe_x   = $signed({4'b0, safety_reg});
        infl_x   = $signed({4'b0, influence_reg});
        low_safe = qmin_x + safe_x;
        up_safe  = qmax_x - safe_x;
        // The lower row bound is the negated product, so use the reversed
        // distance and keep one product path for both rows.
        d_low    = low_safe - q_x;
        d_up     = up_safe - q_x;
        item_ok  = ({3'b0, s0_reg.joint_id} < MAX_JOINTS)
                   && (qmin_x < qmax_x) && (low_safe < up_safe);

        s1_next.pass_start = s0_reg.pass_start;
        s1_next.joint_id   = s0_reg.joint_id;
        s1_next.want_low   = item_ok && (q_x <= qmin_x + infl_x);
        s1_next.want_up    = item_ok && (q_x >= qmax_x - infl_x);
        s1_next.pl_low     = 42'(gain_lower_reg) * 42'(d_low[17:0]);
        s1_next.ph_low     = 42'($signed({1'b0, gain_lower_reg}))
                             * 42'($signed(d_low[34:18]));
        s1_next.pl_up      = 42'(gain_upper_reg) * 42'(d_up[17:0]);
        s1_next.ph_up      = 42'($signed({1'b0, gain_upper_reg}))
                             * 42'($signed(d_up[34:18]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && s0_valid_reg) begin
            s1_reg <= s1_next;
        end
    end

    // Product assembly, rounding and saturation.
    always_comb begin
        s2_next.pass_start = s1_reg.pass_start;
        s2_next.joint_id   = s1_reg.joint_id;
        s2_next.want_low   = s1_reg.want_low;
        s2_next.want_up    = s1_reg.want_up;
        s2_next.bound_low  = round_bound(s1_reg.pl_low, s1_reg.ph_low);
        s2_next.bound_high = round_bound(s1_reg.pl_up, s1_reg.ph_up);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_valid_reg) begin
            s2_reg <= s2_next;
        end
    end

    // Row numbering and capacity tracking.
    emit_state_t st_reg, st_next;
    logic [8:0]  next_row_reg, next_row_next;
    logic        cap_reg, cap_next;
    logic [7:0]  up_row_reg;
    logic [8:0]  eff_cap, cur_row, row1, row2;
    logic        cur_cap, cap1, cap2, low_ok, up_ok, any_row, both_rows;
    logic        out_free, step0, emit, emit_upper, emit_last;
    logic [7:0]  emit_row;

    assign out_free = !m_tvalid || m_tready;

    always_comb begin
        eff_cap   = (row_cap_reg > CAP_LIMIT) ? CAP_LIMIT : row_cap_reg;
        cur_row   = s2_reg.pass_start ? {1'b0, first_row_reg} : next_row_reg;
        cur_cap   = s2_reg.pass_start ? 1'b0 : cap_reg;
        low_ok    = s2_reg.want_low && !cur_cap && (cur_row < eff_cap);
        cap1      = cur_cap || (s2_reg.want_low && !low_ok);
        row1      = cur_row + {8'b0, low_ok};
        up_ok     = s2_reg.want_up && !cap1 && (row1 < eff_cap);
        cap2      = cap1 || (s2_reg.want_up && !up_ok);
        row2      = row1 + {8'b0, up_ok};
        any_row   = low_ok || up_ok;
        both_rows = low_ok && up_ok;

        step0     = s2_valid_reg && (st_reg == EMIT_FIRST) && (!any_row || out_free);
        s2_done   = (step0 && !both_rows)
                    || (s2_valid_reg && (st_reg == EMIT_UPPER) && out_free);

        // What goes into the output register this cycle.
        emit       = 1'b0;
        emit_upper = 1'b0;
        emit_last  = 1'b1;
        emit_row   = cur_row[7:0];
        if (s2_valid_reg && out_free) begin
            unique case (st_reg)
                EMIT_FIRST: begin
                    emit       = any_row;
                    emit_upper = !low_ok;
                    emit_last  = !both_rows;
                    emit_row   = cur_row[7:0];
                end
                EMIT_UPPER: begin
                    emit       = 1'b1;
                    emit_upper = 1'b1;
                    emit_last  = 1'b1;
                    emit_row   = up_row_reg;
                end
                default: ;
            endcase
        end

        st_next       = st_reg;
        next_row_next = next_row_reg;
        cap_next      = cap_reg;
        if (step0) begin
            next_row_next = row2;
            cap_next      = cap2;
            if (both_rows) begin
                st_next = EMIT_UPPER;
            end
        end else if (s2_valid_reg && (st_reg == EMIT_UPPER) && out_free) begin
            st_next = EMIT_FIRST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= EMIT_FIRST;
            next_row_reg <= '0;
            cap_reg      <= 1'b0;
        end else begin
            st_reg       <= st_next;
            next_row_reg <= next_row_next;
            cap_reg      <= cap_next;
        end
    end

    // The upper row of a two-row item takes the number after the lower row.
    always_ff @(posedge aclk) begin
        if (step0 && both_rows) begin
            up_row_reg <= row1[7:0];
        end
    end

    // Output register.
    logic        m_valid_reg;
    logic [79:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg[7:0]   <= emit_row;
            m_data_reg[11:8]  <= s2_reg.joint_id;
            m_data_reg[43:12] <= emit_upper ? 32'd0 : s2_reg.bound_low;
            m_data_reg[75:44] <= emit_upper ? s2_reg.bound_high : 32'd0;
            m_data_reg[79:76] <= 4'd0;
            m_user_reg        <= emit_upper ? 2'b01 : 2'b10;
            m_last_reg        <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTH
    // A pending upper row always belongs to an item held in the last stage.
    a_upper_has_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == EMIT_UPPER) |-> s2_valid_reg)
        else $error("upper row pending with no item in the last stage");

    // A pending upper row was granted, so capacity cannot be marked full.
    a_upper_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == EMIT_UPPER) |-> !cap_reg)
        else $error("upper row pending while capacity is marked reached");

    // Every issued row number lies below the effective capacity.
    a_row_in_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> ({1'b0, emit_row} < eff_cap))
        else $error("row number issued at or beyond capacity");

    // After the first row of a two-row item, the upper row follows next.
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (step0 && both_rows) |=> (st_reg == EMIT_UPPER))
        else $error("two-row item did not move on to its upper row");
`endif

endmodule
